>>> sv/mcgm_pkg.sv
// mcgm_pkg: shared types, constants and helper functions of the gradient magnitude block
// no dependencies; used by every module of the block
`default_nettype none

package mcgm_pkg;

	// sample and channel layout
	localparam int PIX_W        = 8;
	localparam int IN_CHANNELS  = 3;

	// defaults for top-level parameters
	localparam int DEF_MAX_WIDTH = 2048;
	localparam int DEF_CHANNELS  = 3;

	// configuration port
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_W-1:0]     WIDTH_RESET      = CFG_W'(640);
	localparam logic [CFG_W-1:0]     HEIGHT_RESET     = CFG_W'(480);
	localparam int                   MIN_DIM          = 3;

	// counters and arithmetic widths
	localparam int ROW_W       = 12;
	localparam int DIFF_W      = PIX_W + 1;
	localparam int SQ_W        = 2 * PIX_W + 1;
	localparam int ROOT_W      = 8;
	localparam int REM_W       = ROOT_W + 3;
	localparam int SQRT_STEPS  = ROOT_W / 2;

	// queue between front and back
	localparam int Q_DEPTH = 2;

	// classification of one accepted word
	typedef struct packed {
		logic pixel;   // real pixel: touches the line stores
		logic emit;    // gives a result
		logic border;  // result is forced to zero
		logic eof;     // last result of the frame
	} cmd_flags_t;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0]  rem;
	} sqrt_t;

	function automatic int used_channels(input int channels);
		return (channels > IN_CHANNELS) ? IN_CHANNELS : channels;
	endfunction

	// four steps of the digit-by-digit square root, two radicand bits each
	function automatic sqrt_t sqrt_step4(input logic [ROOT_W-1:0] root_in,
			input logic [REM_W-1:0] rem_in, input logic [ROOT_W-1:0] digits);
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0]  rem;
		logic [REM_W-1:0]  trial;
		sqrt_t             res;
		root = root_in;
		rem  = rem_in;
		for (int i = SQRT_STEPS - 1; i >= 0; i--) begin
			rem   = {rem[REM_W-3:0], digits[2*i+1 -: 2]};
			trial = REM_W'({root, 2'b01});
			if (rem >= trial) begin
				rem  = rem - trial;
				root = {root[ROOT_W-2:0], 1'b1};
			end else begin
				root = {root[ROOT_W-2:0], 1'b0};
			end
		end
		res.root = root;
		res.rem  = rem;
		return res;
	endfunction

endpackage

`default_nettype wire

>>> sv/mcgm_front.sv
// mcgm_front: configuration registers, column/row counters and word classification
// depends on mcgm_pkg; feeds mcgm_queue
`default_nettype none

module mcgm_front #(
	parameter int MAX_WIDTH = mcgm_pkg::DEF_MAX_WIDTH,
	parameter int CHANNELS  = mcgm_pkg::DEF_CHANNELS,
	localparam int COL_W    = $clog2(MAX_WIDTH),
	localparam int SW       = mcgm_pkg::used_channels(CHANNELS) * mcgm_pkg::PIX_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [mcgm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mcgm_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mcgm_pkg::PIX_W-1:0]      channel_0,
	input  logic [mcgm_pkg::PIX_W-1:0]      channel_1,
	input  logic [mcgm_pkg::PIX_W-1:0]      channel_2,
	input  logic                            flush,
	output logic                            push_valid,
	input  logic                            push_ready,
	output mcgm_pkg::cmd_flags_t            push_flags,
	output logic [SW-1:0]                   push_pix,
	output logic [COL_W-1:0]                push_col,
	output logic [COL_W-1:0]                push_rcol
);

	localparam int EW = (COL_W + 1 > mcgm_pkg::CFG_W) ? COL_W + 1 : mcgm_pkg::CFG_W;

	logic [mcgm_pkg::CFG_W-1:0] width_q;
	logic [mcgm_pkg::CFG_W-1:0] height_q;
	logic [COL_W-1:0]           col_q;
	logic [mcgm_pkg::ROW_W-1:0] row_q;

	logic [EW-1:0]              width_ext;
	logic [EW-1:0]              eff_w;
	logic [mcgm_pkg::CFG_W-1:0] eff_h;
	logic [COL_W-1:0]           col_eff;
	logic [EW-1:0]              col_nxt_ext;
	logic                       last_col;
	logic                       trailing;
	logic                       keep;
	logic                       take;
	logic [mcgm_pkg::IN_CHANNELS*mcgm_pkg::PIX_W-1:0] pix_all;

	always_comb begin
		width_ext = EW'(width_q);
		if (width_ext < EW'(mcgm_pkg::MIN_DIM)) begin
			eff_w = EW'(mcgm_pkg::MIN_DIM);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = width_ext;
		end
		eff_h = (height_q < mcgm_pkg::CFG_W'(mcgm_pkg::MIN_DIM)) ?
			mcgm_pkg::CFG_W'(mcgm_pkg::MIN_DIM) : height_q;

		if (EW'(col_q) >= eff_w) begin
			col_eff = COL_W'(eff_w - EW'(1));
		end else begin
			col_eff = col_q;
		end
		col_nxt_ext = EW'(col_eff) + EW'(1);
		last_col    = col_nxt_ext >= eff_w;
		trailing    = row_q >= mcgm_pkg::ROW_W'(eff_h);

		// a stray flush word is swallowed without a trace
		keep = trailing || !flush;
		take = in_valid && push_ready && keep;

		in_ready   = push_ready;
		push_valid = in_valid && keep;

		push_flags.pixel  = !trailing;
		push_flags.emit   = trailing || (row_q != '0);
		push_flags.border = trailing || (row_q < mcgm_pkg::ROW_W'(2)) ||
			(col_eff == '0) || last_col;
		push_flags.eof    = trailing && last_col;

		pix_all   = {channel_2, channel_1, channel_0};
		push_pix  = pix_all[SW-1:0];
		push_col  = col_eff;
		push_rcol = last_col ? col_eff : COL_W'(col_nxt_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mcgm_pkg::WIDTH_RESET;
			height_q <= mcgm_pkg::HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mcgm_pkg::REG_FRAME_WIDTH: begin
					width_q <= cfg_data;
					col_q   <= '0;
					row_q   <= '0;
				end
				mcgm_pkg::REG_FRAME_HEIGHT: begin
					height_q <= cfg_data;
					col_q    <= '0;
					row_q    <= '0;
				end
				default: ;
			endcase
		end else if (take) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= trailing ? '0 : row_q + mcgm_pkg::ROW_W'(1);
			end else begin
				col_q <= COL_W'(col_nxt_ext);
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/mcgm_queue.sv
// mcgm_queue: short first-in first-out buffer between front and back
// depends on mcgm_pkg for its depth
`default_nettype none

module mcgm_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  logic [DW-1:0] wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output logic [DW-1:0] rd_data
);

	localparam int PTR_W = $clog2(mcgm_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(mcgm_pkg::Q_DEPTH + 1);

	logic [DW-1:0]    mem_q [mcgm_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = count_q != CNT_W'(mcgm_pkg::Q_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(mcgm_pkg::Q_DEPTH - 1)) ? '0 :
					wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(mcgm_pkg::Q_DEPTH - 1)) ? '0 :
					rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/mcgm_back.sv
// mcgm_back: line stores, central differences, channel maximum and square root pipeline
// depends on mcgm_pkg; fed by mcgm_queue
`default_nettype none

module mcgm_back #(
	parameter int MAX_WIDTH = mcgm_pkg::DEF_MAX_WIDTH,
	parameter int CHANNELS  = mcgm_pkg::DEF_CHANNELS,
	localparam int COL_W    = $clog2(MAX_WIDTH),
	localparam int USED     = mcgm_pkg::used_channels(CHANNELS),
	localparam int SW       = USED * mcgm_pkg::PIX_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  mcgm_pkg::cmd_flags_t          cmd_flags,
	input  logic [SW-1:0]                 cmd_pix,
	input  logic [COL_W-1:0]              cmd_col,
	input  logic [COL_W-1:0]              cmd_rcol,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mcgm_pkg::ROOT_W-1:0]   magnitude,
	output logic                          end_of_frame
);

	localparam int PW = mcgm_pkg::PIX_W;
	localparam int DW = mcgm_pkg::DIFF_W;
	localparam int QW = mcgm_pkg::SQ_W;
	localparam int RW = mcgm_pkg::ROOT_W;

	// line stores: row r-2 and row r-1
	logic [SW-1:0] above_mem  [MAX_WIDTH];
	logic [SW-1:0] center_mem [MAX_WIDTH];

	logic adv;
	logic pop;

	// stage 1: store read data and the word itself
	logic                 v_s1;
	mcgm_pkg::cmd_flags_t flags_s1;
	logic [SW-1:0]        pix_s1;
	logic [COL_W-1:0]     col_s1;
	logic [SW-1:0]        center_s1;
	logic [SW-1:0]        right_s1;
	logic [SW-1:0]        above_s1;
	logic [SW-1:0]        left_q;

	// stage 2: differences
	logic                 v_s2;
	logic                 eof_s2;
	logic signed [DW-1:0] gx_s2 [USED];
	logic signed [DW-1:0] gy_s2 [USED];

	// stage 3: sum of squares per channel
	logic                 v_s3;
	logic                 eof_s3;
	logic [QW-1:0]        sq_s3 [USED];

	// stage 4: largest channel
	logic                 v_s4;
	logic                 eof_s4;
	logic                 sat_s4;
	logic [2*RW-1:0]      val_s4;
	logic [QW-1:0]        best;

	// stage 5: upper half of the root
	logic                 v_s5;
	logic                 eof_s5;
	logic                 sat_s5;
	logic [RW-1:0]        lo_s5;
	logic [RW-1:0]        root_s5;
	logic [mcgm_pkg::REM_W-1:0] rem_s5;
	mcgm_pkg::sqrt_t      half;
	mcgm_pkg::sqrt_t      full;

	// output register
	logic                 out_valid_q;
	logic                 eof_q;
	logic [RW-1:0]        mag_q;

	assign adv          = !out_valid_q || out_ready;
	assign cmd_ready    = adv;
	assign pop          = cmd_valid && adv;
	assign out_valid    = out_valid_q;
	assign magnitude    = mag_q;
	assign end_of_frame = eof_q;

	// in a frame, the next word's reads never hit the address the current word writes
	always_ff @(posedge clk) begin
		if (pop) begin
			center_s1 <= center_mem[cmd_col];
			right_s1  <= center_mem[cmd_rcol];
			above_s1  <= above_mem[cmd_col];
			pix_s1    <= cmd_pix;
			col_s1    <= cmd_col;
			flags_s1  <= cmd_flags;
		end
		if (adv && v_s1 && flags_s1.pixel) begin
			above_mem[col_s1]  <= center_s1;
			center_mem[col_s1] <= pix_s1;
			left_q             <= center_s1;
		end
	end

	for (genvar i = 0; i < USED; i++) begin : g_lane
		logic signed [2*DW-1:0] gxx;
		logic signed [2*DW-1:0] gyy;
		logic signed [2*DW-1:0] ssum;

		assign gxx  = gx_s2[i] * gx_s2[i];
		assign gyy  = gy_s2[i] * gy_s2[i];
		assign ssum = gxx + gyy;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (flags_s1.border) begin
					gx_s2[i] <= '0;
					gy_s2[i] <= '0;
				end else begin
					gx_s2[i] <= $signed({1'b0, right_s1[i*PW +: PW]}) -
						$signed({1'b0, left_q[i*PW +: PW]});
					gy_s2[i] <= $signed({1'b0, pix_s1[i*PW +: PW]}) -
						$signed({1'b0, above_s1[i*PW +: PW]});
				end
				sq_s3[i] <= ssum[QW-1:0];
			end
		end
	end

	// lowest channel wins ties
	always_comb begin
		best = '0;
		for (int i = 0; i < USED; i++) begin
			if (sq_s3[i] > best) begin
				best = sq_s3[i];
			end
		end
		half = mcgm_pkg::sqrt_step4('0, '0, val_s4[2*RW-1:RW]);
		full = mcgm_pkg::sqrt_step4(root_s5, rem_s5, lo_s5);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eof_s2  <= flags_s1.eof;
			eof_s3  <= eof_s2;
			eof_s4  <= eof_s3;
			sat_s4  <= best[QW-1];
			val_s4  <= best[2*RW-1:0];
			eof_s5  <= eof_s4;
			sat_s5  <= sat_s4;
			lo_s5   <= val_s4[RW-1:0];
			root_s5 <= half.root;
			rem_s5  <= half.rem;
			eof_q   <= eof_s5;
			mag_q   <= sat_s5 ? '1 : full.root;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= cmd_valid;
			v_s2        <= v_s1 && flags_s1.emit;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

endmodule

`default_nettype wire

>>> sv/max_channel_gradient_magnitude_top.sv
// max_channel_gradient_magnitude_top: streaming gradient magnitude over the strongest channel
// depends on mcgm_pkg, mcgm_front, mcgm_queue, mcgm_back
//
//   port group   direction  handshake              payload
//   cfg          in         cfg_write              cfg_index, cfg_data
//   in           in         in_valid / in_ready    channel_0..2, flush
//   out          out        out_valid / out_ready  magnitude, end_of_frame
//
// one word per clock sustained while the output is not stalled
// the pipeline steps as a whole, set by the output register: a stalled result holds it
// the two-entry queue takes one or two more words once an output stall begins,
// one when words have been arriving every clock
// reset clears counters, configuration registers and valid bits, not the line stores;
// a result never uses an entry the frame has not written: rows 0 and 1 give zero or none
`default_nettype none

module max_channel_gradient_magnitude_top #(
	parameter int MAX_WIDTH = mcgm_pkg::DEF_MAX_WIDTH,
	parameter int CHANNELS  = mcgm_pkg::DEF_CHANNELS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [mcgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcgm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mcgm_pkg::PIX_W-1:0]     channel_0,
	input  logic [mcgm_pkg::PIX_W-1:0]     channel_1,
	input  logic [mcgm_pkg::PIX_W-1:0]     channel_2,
	input  logic                           flush,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mcgm_pkg::ROOT_W-1:0]    magnitude,
	output logic                           end_of_frame
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int SW    = mcgm_pkg::used_channels(CHANNELS) * mcgm_pkg::PIX_W;
	localparam int FW    = $bits(mcgm_pkg::cmd_flags_t);
	localparam int QW    = FW + SW + 2 * COL_W;

	logic                 q_wr_valid;
	logic                 q_wr_ready;
	mcgm_pkg::cmd_flags_t push_flags;
	logic [SW-1:0]        push_pix;
	logic [COL_W-1:0]     push_col;
	logic [COL_W-1:0]     push_rcol;
	logic [QW-1:0]        q_wr_data;
	logic                 q_rd_valid;
	logic                 q_rd_ready;
	logic [QW-1:0]        q_rd_data;
	mcgm_pkg::cmd_flags_t pop_flags;
	logic [SW-1:0]        pop_pix;
	logic [COL_W-1:0]     pop_col;
	logic [COL_W-1:0]     pop_rcol;

	mcgm_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.CHANNELS  (CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.channel_0  (channel_0),
		.channel_1  (channel_1),
		.channel_2  (channel_2),
		.flush      (flush),
		.push_valid (q_wr_valid),
		.push_ready (q_wr_ready),
		.push_flags (push_flags),
		.push_pix   (push_pix),
		.push_col   (push_col),
		.push_rcol  (push_rcol)
	);

	assign q_wr_data = {push_flags, push_pix, push_col, push_rcol};

	mcgm_queue #(
		.DW (QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_data  (q_wr_data),
		.rd_valid (q_rd_valid),
		.rd_ready (q_rd_ready),
		.rd_data  (q_rd_data)
	);

	assign {pop_flags, pop_pix, pop_col, pop_rcol} = q_rd_data;

	mcgm_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.CHANNELS  (CHANNELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_rd_valid),
		.cmd_ready    (q_rd_ready),
		.cmd_flags    (pop_flags),
		.cmd_pix      (pop_pix),
		.cmd_col      (pop_col),
		.cmd_rcol     (pop_rcol),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.magnitude    (magnitude),
		.end_of_frame (end_of_frame)
	);

	// the frame's last result lies on the bottom border
	a_eof_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> magnitude == '0)
		else $error("end of frame with non-zero magnitude");

	// a held result freezes the back, so nothing leaves the queue
	a_stall_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !(q_rd_valid && q_rd_ready))
		else $error("queue popped while output stalled");

	// end of frame only comes from a filler word of the trailing row
	a_eof_trailing: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr_valid && push_flags.eof |->
			push_flags.emit && push_flags.border && !push_flags.pixel)
		else $error("end of frame on a pixel word");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for max_channel_gradient_magnitude_top, with its own gradient predictor
// depends on mcgm_pkg and max_channel_gradient_magnitude_top; bursty sender, stalling receiver

module tb_top;
	import mcgm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
	localparam int MAX_HEIGHT = 4095;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [PIX_W-1:0] ch0;
		logic [PIX_W-1:0] ch1;
		logic [PIX_W-1:0] ch2;
		logic             fl;
	} pix_word_t;

	typedef struct packed {
		logic [ROOT_W-1:0] mag;
		logic              eof;
	} grad_res_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PIX_W-1:0] channel_0 = '0;
	logic [PIX_W-1:0] channel_1 = '0;
	logic [PIX_W-1:0] channel_2 = '0;
	logic flush = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ROOT_W-1:0] magnitude;
	logic end_of_frame;

	max_channel_gradient_magnitude_top #(
		.MAX_WIDTH(DEF_MAX_WIDTH),
		.CHANNELS (DEF_CHANNELS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.channel_0   (channel_0),
		.channel_1   (channel_1),
		.channel_2   (channel_2),
		.flush       (flush),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.magnitude   (magnitude),
		.end_of_frame(end_of_frame)
	);

	// predictor state
	logic [CFG_W-1:0] reg_width;
	logic [CFG_W-1:0] reg_height;
	logic [3*PIX_W-1:0] line_top [DEF_MAX_WIDTH];
	logic [3*PIX_W-1:0] line_mid [DEF_MAX_WIDTH];
	logic [3*PIX_W-1:0] left_px;
	int col_cnt;
	int row_cnt;

	pix_word_t pixel_q[$];
	grad_res_t mag_expected_q[$];
	int err_cnt = 0;
	int loop_words;

	int burst_left = 0;
	int gap_left = 0;
	pix_word_t next_word;

	rx_mode_e rx_mode = RX_OPEN;
	int rx_left = 0;
	int rx_tick = 0;
	logic rx_rdy;
	grad_res_t want;
	grad_res_t pred;
	bit pred_valid;

	function automatic int eff_width(input logic [CFG_W-1:0] v);
		return (v < MIN_DIM) ? MIN_DIM : (v > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(v);
	endfunction

	function automatic int eff_height(input logic [CFG_W-1:0] v);
		return (v < MIN_DIM) ? MIN_DIM : (v > MAX_HEIGHT) ? MAX_HEIGHT : int'(v);
	endfunction

	task automatic report_mismatch(input string what);
		err_cnt++;
		$display("%0t ns: %s", $time, what);
	endtask

	// one accepted word in, at most one magnitude out; the stores lag by one row
	task automatic predict_gradient(input pix_word_t p, output bit has_res,
			output grad_res_t res);
		int w, h, c, r, best, s, gx, gy, a, b, root;
		bit trailing;
		logic [3*PIX_W-1:0] cur, old_mid, right_px, above_px;
		w = eff_width(reg_width);
		h = eff_height(reg_height);
		c = col_cnt;
		r = row_cnt;
		trailing = (r >= h);
		has_res = 1'b0;
		res = '0;
		if (c >= w)
			c = w - 1;
		if (trailing) begin
			has_res = 1'b1;
			res.eof = (c == w - 1);
		end else if (p.fl) begin
			// stray flush outside the trailing row: no effect at all
			return;
		end else begin
			cur = {p.ch2, p.ch1, p.ch0};
			old_mid = line_mid[c];
			if (r >= 1) begin
				has_res = 1'b1;
				if (r >= 2 && c >= 1 && c + 1 < w) begin
					right_px = line_mid[c + 1];
					above_px = line_top[c];
					best = 0;
					for (int ch = 0; ch < IN_CHANNELS; ch++) begin
						a = right_px[PIX_W*ch +: PIX_W];
						b = left_px[PIX_W*ch +: PIX_W];
						gx = a - b;
						a = cur[PIX_W*ch +: PIX_W];
						b = above_px[PIX_W*ch +: PIX_W];
						gy = a - b;
						s = gx * gx + gy * gy;
						if (s > best)
							best = s;
					end
					root = 0;
					while (root < 255 && (root + 1) * (root + 1) <= best)
						root++;
					res.mag = root[ROOT_W-1:0];
				end
			end
			line_top[c] = old_mid;
			line_mid[c] = cur;
			left_px = old_mid;
		end
		if (c + 1 >= w) begin
			col_cnt = 0;
			left_px = '0;
			row_cnt = trailing ? 0 : ((r + 1) & 'hFFF);
		end else begin
			col_cnt = c + 1;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
			if (idx == REG_FRAME_WIDTH)
				reg_width = val;
			else
				reg_height = val;
			col_cnt = 0;
			row_cnt = 0;
			left_px = '0;
		end
		@(negedge clk);
	endtask

	task automatic add_pix(input int c0, input int c1, input int c2, input bit fl);
		pixel_q.push_back({PIX_W'(c0), PIX_W'(c1), PIX_W'(c2), fl});
	endtask

	// image words of one frame from its start; a complete frame gets its trailing row
	task automatic queue_frame(input int w, input int h, input int n_pix,
			input bit low_contrast);
		pix_word_t p;
		int base, kind;
		base = $urandom_range(0, 252);
		for (int i = 0; i < n_pix; i++) begin
			if ($urandom_range(0, 31) == 0)
				pixel_q.push_back({PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 1'b1});
			kind = $urandom_range(0, 9);
			p.fl = 1'b0;
			if (low_contrast) begin
				p.ch0 = PIX_W'(base + $urandom_range(0, 3));
				p.ch1 = PIX_W'(base + $urandom_range(0, 3));
				p.ch2 = PIX_W'(base + $urandom_range(0, 3));
			end else if (kind == 0) begin
				p.ch0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.ch1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.ch2 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end else if (kind == 1) begin
				p.ch0 = PIX_W'($urandom);
				p.ch1 = p.ch0;
				p.ch2 = p.ch0;
			end else begin
				p.ch0 = PIX_W'($urandom);
				p.ch1 = PIX_W'($urandom);
				p.ch2 = PIX_W'($urandom);
			end
			pixel_q.push_back(p);
			loop_words++;
		end
		if (n_pix == w * h) begin
			for (int i = 0; i < w; i++) begin
				pixel_q.push_back({PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
					1'($urandom_range(0, 1))});
				loop_words++;
			end
		end
	endtask

	// all words taken, all results back, then room for words that give nothing
	task automatic drain_pipeline();
		int waited;
		waited = 0;
		do @(negedge clk); while (pixel_q.size() != 0 || in_valid);
		while (mag_expected_q.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		if (mag_expected_q.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", mag_expected_q.size()));
			mag_expected_q.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// sender: bursts of random length separated by random gaps, some of them empty
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (pixel_q.size() != 0) begin
				next_word = pixel_q.pop_front();
				channel_0 <= next_word.ch0;
				channel_1 <= next_word.ch1;
				channel_2 <= next_word.ch2;
				flush <= next_word.fl;
				in_valid <= 1'b1;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks results first, then predicts from the word taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_left = 0;
			rx_tick = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (mag_expected_q.size() == 0) begin
					report_mismatch($sformatf("result mag %0d eof %0b with none pending",
						magnitude, end_of_frame));
				end else begin
					want = mag_expected_q.pop_front();
					if (magnitude !== want.mag)
						report_mismatch($sformatf("magnitude %0d, expected %0d",
							magnitude, want.mag));
					if (end_of_frame !== want.eof)
						report_mismatch($sformatf("end_of_frame %0b, expected %0b",
							end_of_frame, want.eof));
				end
			end
			if (in_valid && in_ready) begin
				predict_gradient({channel_0, channel_1, channel_2, flush}, pred_valid, pred);
				if (pred_valid)
					mag_expected_q.push_back(pred);
			end
			if (rx_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				rx_left = $urandom_range(4, 80);
				rx_tick = 0;
			end
			rx_left = rx_left - 1;
			rx_tick = rx_tick + 1;
			case (rx_mode)
				RX_OPEN:   rx_rdy = 1'b1;
				RX_COIN:   rx_rdy = 1'($urandom_range(0, 1));
				RX_SPARSE: rx_rdy = (rx_tick % 3 == 0);
				default:   rx_rdy = (rx_tick % 12 == 0);
			endcase
			out_ready <= rx_rdy;
		end
	end

	initial begin
		int w, h, sel, phase, n_frames;
		reg_width = WIDTH_RESET;
		reg_height = HEIGHT_RESET;
		col_cnt = 0;
		row_cnt = 0;
		left_px = '0;
		loop_words = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default geometry: a row and a bit, then restarted by the writes below
		queue_frame(eff_width(WIDTH_RESET), eff_height(HEIGHT_RESET),
			eff_width(WIDTH_RESET) + 8, 1'b0);
		drain_pipeline();

		// smallest frame: saturating gradient, stray flushes, ignored filler samples
		write_reg(REG_FRAME_WIDTH, CFG_W'(3));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
		add_pix(8'hA5, 8'h5A, 8'hFF, 1'b1);
		add_pix(0, 0, 0, 1'b0);
		add_pix(0, 0, 0, 1'b0);
		add_pix(0, 0, 0, 1'b0);
		add_pix(0, 0, 0, 1'b0);
		add_pix(128, 64, 32, 1'b0);
		add_pix(255, 255, 255, 1'b1);
		add_pix(255, 255, 255, 1'b0);
		add_pix(0, 0, 0, 1'b0);
		add_pix(255, 255, 255, 1'b0);
		add_pix(0, 0, 0, 1'b0);
		add_pix(255, 255, 255, 1'b1);
		add_pix(0, 0, 0, 1'b0);
		add_pix(255, 0, 255, 1'b1);
		// every channel scores the same: the tie goes to the first
		add_pix(1, 2, 3, 1'b0);
		add_pix(10, 20, 5, 1'b0);
		add_pix(200, 100, 50, 1'b0);
		add_pix(7, 30, 9, 1'b0);
		add_pix(99, 99, 99, 1'b0);
		add_pix(10, 26, 9, 1'b0);
		add_pix(4, 4, 4, 1'b0);
		add_pix(14, 17, 0, 1'b0);
		add_pix(8, 8, 8, 1'b0);
		add_pix(0, 0, 0, 1'b0);
		add_pix(0, 0, 0, 1'b1);
		add_pix(0, 0, 0, 1'b0);
		drain_pipeline();

		// register values below the range, clamped up
		write_reg(REG_FRAME_WIDTH, CFG_W'(0));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(0));
		queue_frame(3, 3, 9, 1'b0);
		queue_frame(3, 3, 9, 1'b1);
		drain_pipeline();

		// random geometries, some frames cut short by the next write
		phase = 0;
		while (loop_words < 1700) begin
			sel = $urandom_range(0, 9);
			if (sel == 0 && phase > 0) begin
				// writes past the register list leave the frame running
				write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
			end else begin
				if (sel != 1)
					write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 7) == 0)
						? CFG_W'($urandom_range(0, 2)) : CFG_W'($urandom_range(3, 20)));
				write_reg(REG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0)
					? CFG_W'($urandom_range(0, 2)) : CFG_W'($urandom_range(3, 7)));
			end
			w = eff_width(reg_width);
			h = eff_height(reg_height);
			n_frames = $urandom_range(1, 3);
			for (int f = 0; f < n_frames; f++)
				queue_frame(w, h, w * h, $urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0)
				queue_frame(w, h, $urandom_range(1, w * h - 1), 1'b0);
			drain_pipeline();
			phase++;
		end

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> files.f
sv/mcgm_pkg.sv
sv/mcgm_front.sv
sv/mcgm_queue.sv
sv/mcgm_back.sv
sv/max_channel_gradient_magnitude_top.sv
tb/sv/tb_top.sv
